### rtl/khreq_pkg.sv
// Shared constants, payload types and command codes for the key hold/release event queue.
package khreq_pkg;

  localparam int NUM_KEYS    = 256;
  localparam int QUEUE_DEPTH = 64;
  localparam int KEY_W       = 8;
  localparam int KEY_IDX_W   = $clog2(NUM_KEYS);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int TIME_W      = 32;
  localparam int RT_W        = 11;

  localparam logic [RT_W-1:0] RT_RESET = 11'd180;
  localparam logic [RT_W-1:0] RT_MIN   = 11'd30;
  localparam logic [RT_W-1:0] RT_MAX   = 11'd2000;

  // command queue between front and back
  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);

  // request kind codes on the port
  localparam logic [1:0] KIND_HIT   = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_FETCH = 2'd2;

  typedef enum logic [1:0] {
    OP_HIT   = 2'd0,
    OP_TICK  = 2'd1,
    OP_FETCH = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] key_in;
  } cmd_t;

  typedef struct packed {
    logic             have_event;
    logic             key_pressed;
    logic [KEY_W-1:0] key_out;
  } evt_t;

  typedef struct packed {
    op_t                  op;
    logic [KEY_IDX_W-1:0] key;
  } op_item_t;

  typedef struct packed {
    logic             pressed;
    logic [KEY_W-1:0] key;
  } evq_entry_t;

endpackage

### rtl/khreq_front.sv
// Front end: accepts requests, drops ones with no effect, registers a decoded op.
module khreq_front import khreq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  cmd_t     cmd,
  output logic     op_valid,
  input  logic     op_ready,
  output op_item_t op
);

  op_item_t op_next;
  logic     keep;

  assign cmd_ready = !op_valid || op_ready;

  always_comb begin
    keep        = 1'b0;
    op_next.op  = OP_TICK;
    op_next.key = cmd.key_in[KEY_IDX_W-1:0];
    case (cmd.kind)
      KIND_HIT: begin
        keep       = int'(cmd.key_in) < NUM_KEYS;
        op_next.op = OP_HIT;
      end
      KIND_TICK: begin
        keep       = 1'b1;
        op_next.op = OP_TICK;
      end
      KIND_FETCH: begin
        keep       = 1'b1;
        op_next.op = OP_FETCH;
      end
      default: keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (cmd_ready) begin
      op_valid <= cmd_valid && keep;
    end
    if (cmd_ready && cmd_valid && keep) begin
      op <= op_next;
    end
  end

endmodule

### rtl/khreq_cmd_fifo.sv
// Short op queue that decouples the front end from the back end.
module khreq_cmd_fifo import khreq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  op_item_t in_op,
  output logic     out_valid,
  input  logic     out_ready,
  output op_item_t out_op
);

  op_item_t            slots [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr;
  logic [CQ_PTR_W-1:0] rd_ptr;
  logic [CQ_PTR_W:0]   count;
  logic                push;
  logic                pop;

  assign in_ready  = count != (CQ_PTR_W+1)'(CQ_DEPTH);
  assign out_valid = count != '0;
  assign out_op    = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (push) begin
      slots[wr_ptr] <= in_op;
    end
  end

endmodule

### rtl/khreq_back.sv
// Back end: key state, deadline memory, expiry scan, event queue and result register.
module khreq_back import khreq_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            op_valid,
  output logic            op_ready,
  input  op_item_t        op,
  input  logic [RT_W-1:0] release_time,
  output logic            evt_valid,
  input  logic            evt_ready,
  output evt_t            evt
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_FLUSH = 5'b00100,
    ST_POP   = 5'b01000,
    ST_EMIT  = 5'b10000
  } st_t;

  function automatic logic [QPTR_W-1:0] next_qptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  st_t                  state;
  logic                 held [NUM_KEYS];
  logic [TIME_W-1:0]    dl_mem [NUM_KEYS];
  logic [TIME_W-1:0]    dl_q;
  evq_entry_t           ev_mem [QUEUE_DEPTH];
  evq_entry_t           ev_q;
  logic [TIME_W-1:0]    time_now;
  logic [TIME_W-1:0]    tdiff;
  logic [KEY_IDX_W-1:0] scan_idx;
  logic [KEY_IDX_W-1:0] chk_key;
  logic                 chk_valid;
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QPTR_W-1:0]    wr_inc;
  logic                 pop_have;
  logic                 hit_fire;
  logic                 expire;
  logic                 push_req;
  logic                 push_ok;
  evq_entry_t           push_entry;

  assign op_ready = state == ST_IDLE;
  assign hit_fire = op_valid && (state == ST_IDLE) && (op.op == OP_HIT);
  assign tdiff    = time_now - dl_q;
  assign expire   = chk_valid && held[chk_key] && !tdiff[TIME_W-1];
  assign push_req = (hit_fire && !held[op.key]) || expire;
  assign wr_inc   = next_qptr(wr_ptr);
  assign push_ok  = push_req && (wr_inc != rd_ptr);

  always_comb begin
    if (expire) begin
      push_entry.pressed = 1'b0;
      push_entry.key     = KEY_W'(chk_key);
    end else begin
      push_entry.pressed = 1'b1;
      push_entry.key     = KEY_W'(op.key);
    end
  end

  // held flags: one flop per key, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_KEYS; k++) held[k] <= 1'b0;
    end else if (hit_fire) begin
      held[op.key] <= 1'b1;
    end else if (expire) begin
      held[chk_key] <= 1'b0;
    end
  end

  // deadline memory, registered read at the scan address
  always_ff @(posedge clk) begin
    if (hit_fire) begin
      dl_mem[op.key] <= time_now + TIME_W'(release_time);
    end
    dl_q <= dl_mem[scan_idx];
  end

  // event memory, registered read at the head slot
  always_ff @(posedge clk) begin
    if (push_ok) begin
      ev_mem[wr_ptr] <= push_entry;
    end
    if (state == ST_POP) begin
      ev_q <= ev_mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      time_now  <= '0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      chk_valid <= 1'b0;
      evt_valid <= 1'b0;
    end else begin
      chk_valid <= state == ST_SCAN;
      chk_key   <= scan_idx;
      if (push_ok) wr_ptr <= wr_inc;
      // EMIT drives the result register itself
      if (evt_valid && evt_ready && state != ST_EMIT) evt_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          scan_idx <= '0;
          if (op_valid) begin
            case (op.op)
              OP_TICK:  time_now <= time_now + 1'b1;
              OP_FETCH: state <= ST_SCAN;
              default:  state <= ST_IDLE;
            endcase
          end
        end
        ST_SCAN: begin
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == KEY_IDX_W'(NUM_KEYS - 1)) state <= ST_FLUSH;
        end
        ST_FLUSH: begin
          state <= ST_POP;
        end
        ST_POP: begin
          pop_have <= rd_ptr != wr_ptr;
          if (rd_ptr != wr_ptr) rd_ptr <= next_qptr(rd_ptr);
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!evt_valid || evt_ready) begin
            evt_valid       <= 1'b1;
            evt.have_event  <= pop_have;
            evt.key_pressed <= pop_have & ev_q.pressed;
            evt.key_out     <= pop_have ? ev_q.key : '0;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/key_hold_release_event_queue_top.sv
// Top level of the key hold/release event queue: config register, front, op queue, back.
//
//   channel | signals                       | payload   | carries
//   --------+-------------------------------+-----------+------------------------------
//   cmd     | cmd_valid / cmd_ready         | cmd_t     | request: hit, tick or fetch
//   evt     | evt_valid / evt_ready         | evt_t     | one result per fetch request
//   cfg     | cfg_we / cfg_wdata            | 11 bits   | release_time, no read-back
//
// Hit and tick requests retire directly in the back end's idle state. For a
// fetch, the back end walks the deadline memory one key per cycle through its
// single read port, then pops the event memory. Reset (rst, synchronous) clears
// held flags, time and queue pointers at once; deadline and event memories
// are not cleared. The front end keeps taking requests into a 4-entry op
// queue while the back end scans or waits on a stalled evt channel; the
// result register frees as soon as evt is taken.
module key_hold_release_event_queue_top import khreq_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  cmd_t            cmd,
  output logic            evt_valid,
  input  logic            evt_ready,
  output evt_t            evt,
  input  logic            cfg_we,
  input  logic [RT_W-1:0] cfg_wdata
);

  logic [RT_W-1:0] release_time;

  op_item_t front_op;
  logic     front_valid;
  logic     front_ready;
  op_item_t back_op;
  logic     back_valid;
  logic     back_ready;

  // release_time: writes outside the legal range are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      release_time <= RT_RESET;
    end else if (cfg_we && cfg_wdata >= RT_MIN && cfg_wdata <= RT_MAX) begin
      release_time <= cfg_wdata;
    end
  end

  khreq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .op_valid  (front_valid),
    .op_ready  (front_ready),
    .op        (front_op)
  );

  khreq_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_op     (front_op),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_op    (back_op)
  );

  khreq_back u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (back_valid),
    .op_ready     (back_ready),
    .op           (back_op),
    .release_time (release_time),
    .evt_valid    (evt_valid),
    .evt_ready    (evt_ready),
    .evt          (evt)
  );

  // an empty fetch carries an all-zero event
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt.have_event |-> !evt.key_pressed && (evt.key_out == '0))
    else $error("empty fetch result with nonzero payload");

  // release_time never leaves its legal range
  a_rt_range: assert property (@(posedge clk) disable iff (rst)
    release_time >= RT_MIN && release_time <= RT_MAX)
    else $error("release_time out of range");

  // an illegal config write leaves release_time alone
  a_rt_ignore: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_wdata < RT_MIN || cfg_wdata > RT_MAX) |=> $stable(release_time))
    else $error("illegal release_time write took effect");

  // a front op waiting on a full op queue stays put until taken
  a_fifo_handoff: assert property (@(posedge clk) disable iff (rst)
    front_valid && !front_ready |=> front_valid && $stable(front_op))
    else $error("front op lost while op queue full");

endmodule
